/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/dcf_pkg.sv */
// types, constants and helpers for the dcf77 pulse width decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned TICK_W  = 12;
  localparam int unsigned CIDX_W  = 4;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_SECOND_GAP_MIN = 4'd0,
    REG_SECOND_GAP_MAX = 4'd1,
    REG_MARKER_GAP_MIN = 4'd2,
    REG_MARKER_GAP_MAX = 4'd3,
    REG_ZERO_PULSE_MIN = 4'd4,
    REG_ZERO_PULSE_MAX = 4'd5,
    REG_ONE_PULSE_MIN  = 4'd6,
    REG_ONE_PULSE_MAX  = 4'd7
  } cfg_reg_t;

  // reset values of the window bounds
  localparam logic [TICK_W-1:0] RST_SECOND_GAP_MIN = 12'd179;
  localparam logic [TICK_W-1:0] RST_SECOND_GAP_MAX = 12'd256;
  localparam logic [TICK_W-1:0] RST_MARKER_GAP_MIN = 12'd435;
  localparam logic [TICK_W-1:0] RST_MARKER_GAP_MAX = 12'd512;
  localparam logic [TICK_W-1:0] RST_ZERO_PULSE_MIN = 12'd10;
  localparam logic [TICK_W-1:0] RST_ZERO_PULSE_MAX = 12'd33;
  localparam logic [TICK_W-1:0] RST_ONE_PULSE_MIN  = 12'd44;
  localparam logic [TICK_W-1:0] RST_ONE_PULSE_MAX  = 12'd59;

  // all window bounds as one bundle
  typedef struct packed {
    logic [TICK_W-1:0] second_gap_min;
    logic [TICK_W-1:0] second_gap_max;
    logic [TICK_W-1:0] marker_gap_min;
    logic [TICK_W-1:0] marker_gap_max;
    logic [TICK_W-1:0] zero_pulse_min;
    logic [TICK_W-1:0] zero_pulse_max;
    logic [TICK_W-1:0] one_pulse_min;
    logic [TICK_W-1:0] one_pulse_max;
  } cfg_t;

  // decode result for one edge
  typedef struct packed {
    logic              emit;
    logic [WORD_W-1:0] next_shift;
  } dec_t;

  // inclusive window test of a 32-bit width against 12-bit bounds
  function automatic logic in_window(input logic [TIME_W-1:0] width,
                                     input logic [TICK_W-1:0] lo,
                                     input logic [TICK_W-1:0] hi);
    logic [TIME_W-1:0] lo_ext;
    logic [TIME_W-1:0] hi_ext;
    lo_ext = {{(TIME_W-TICK_W){1'b0}}, lo};
    hi_ext = {{(TIME_W-TICK_W){1'b0}}, hi};
    return (width >= lo_ext) && (width <= hi_ext);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dcf_cfg_regs.sv */
// window bound registers written through the configuration channel
// depends on dcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcf_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [dcf_pkg::CIDX_W-1:0] wr_index,
  input  wire logic [dcf_pkg::TICK_W-1:0] wr_data,
  output dcf_pkg::cfg_t                   cfg
);

  dcf_pkg::cfg_t cfg_r;
  dcf_pkg::cfg_t cfg_nxt;

  // register decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (dcf_pkg::cfg_reg_t'(wr_index))
        dcf_pkg::REG_SECOND_GAP_MIN: cfg_nxt.second_gap_min = wr_data;
        dcf_pkg::REG_SECOND_GAP_MAX: cfg_nxt.second_gap_max = wr_data;
        dcf_pkg::REG_MARKER_GAP_MIN: cfg_nxt.marker_gap_min = wr_data;
        dcf_pkg::REG_MARKER_GAP_MAX: cfg_nxt.marker_gap_max = wr_data;
        dcf_pkg::REG_ZERO_PULSE_MIN: cfg_nxt.zero_pulse_min = wr_data;
        dcf_pkg::REG_ZERO_PULSE_MAX: cfg_nxt.zero_pulse_max = wr_data;
        dcf_pkg::REG_ONE_PULSE_MIN:  cfg_nxt.one_pulse_min  = wr_data;
        dcf_pkg::REG_ONE_PULSE_MAX:  cfg_nxt.one_pulse_max  = wr_data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  // bounds come out of reset at the nominal windows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.second_gap_min <= dcf_pkg::RST_SECOND_GAP_MIN;
      cfg_r.second_gap_max <= dcf_pkg::RST_SECOND_GAP_MAX;
      cfg_r.marker_gap_min <= dcf_pkg::RST_MARKER_GAP_MIN;
      cfg_r.marker_gap_max <= dcf_pkg::RST_MARKER_GAP_MAX;
      cfg_r.zero_pulse_min <= dcf_pkg::RST_ZERO_PULSE_MIN;
      cfg_r.zero_pulse_max <= dcf_pkg::RST_ZERO_PULSE_MAX;
      cfg_r.one_pulse_min  <= dcf_pkg::RST_ONE_PULSE_MIN;
      cfg_r.one_pulse_max  <= dcf_pkg::RST_ONE_PULSE_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/dcf_decode.sv */
// edge decode: width between edges, bit shift-in and minute marker detect
// depends on dcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcf_decode (
  input  wire logic                       edge_level,
  input  wire logic [dcf_pkg::TIME_W-1:0] edge_time,
  input  wire logic [dcf_pkg::TIME_W-1:0] last_time,
  input  wire logic [dcf_pkg::WORD_W-1:0] shift,
  input  wire dcf_pkg::cfg_t              cfg,
  output dcf_pkg::dec_t                   dec
);

  logic [dcf_pkg::TIME_W-1:0] width;
  logic [dcf_pkg::WORD_W-1:0] base;
  logic                       is_second;
  logic                       is_marker;
  logic                       is_zero;
  logic                       is_one;

  // width wraps modulo 2^32
  assign width = edge_time - last_time;

  assign is_second = dcf_pkg::in_window(width, cfg.second_gap_min, cfg.second_gap_max);
  assign is_marker = dcf_pkg::in_window(width, cfg.marker_gap_min, cfg.marker_gap_max);
  assign is_zero   = dcf_pkg::in_window(width, cfg.zero_pulse_min, cfg.zero_pulse_max);
  assign is_one    = dcf_pkg::in_window(width, cfg.one_pulse_min, cfg.one_pulse_max);

  // full register restarts, empty register opens with the sentinel
  always_comb begin
    base = shift[dcf_pkg::WORD_W-1] ? '0 : shift;
    if (base == '0) begin
      base = {{(dcf_pkg::WORD_W-1){1'b0}}, 1'b1};
    end
  end

  // next minute register and result flag
  always_comb begin
    dec.emit       = 1'b0;
    dec.next_shift = '0;
    if (edge_level) begin
      if (is_second) begin
        dec.next_shift = shift;
      end else if (is_marker) begin
        dec.emit = 1'b1;
      end
    end else begin
      if (is_zero) begin
        dec.next_shift = {base[dcf_pkg::WORD_W-2:0], 1'b0};
      end else if (is_one) begin
        dec.next_shift = {base[dcf_pkg::WORD_W-2:0], 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dcf77_pulse_width_decoder.sv */
// dcf77 pulse width decoder: one edge word in, minute word out on a marker gap
// decode reads the input register; minute words are held in the output register
// throughput: one edge word per cycle; the input register holds only while
// its word has a result and the output register holds one unread
// reset: synchronous active-low; clears state, loads the nominal window bounds
// depends on dcf_pkg, dcf_cfg_regs, dcf_decode and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dcf77_pulse_width_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // edge words
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic                       in_edge_level,
  input  wire logic [dcf_pkg::TIME_W-1:0] in_edge_time,
  // minute words
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [dcf_pkg::WORD_W-1:0] out_minute_word,
  output      logic [dcf_pkg::TIME_W-1:0] out_marker_time,
  // configuration writes
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [dcf_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [dcf_pkg::TICK_W-1:0] cfg_data
);

  dcf_pkg::cfg_t cfg;
  dcf_pkg::dec_t dec;

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       s1_level_r;
  logic [dcf_pkg::TIME_W-1:0] s1_time_r;
  logic [dcf_pkg::TIME_W-1:0] last_time_r;
  logic [dcf_pkg::WORD_W-1:0] shift_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [dcf_pkg::WORD_W-1:0] out_word_r;
  logic [dcf_pkg::TIME_W-1:0] out_time_r;
  logic                       in_take;
  logic                       s1_advance;

  // configuration registers
  assign cfg_ready = 1'b1;

  dcf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // decode of the word in the input register
  dcf_decode u_dec (
    .edge_level (s1_level_r),
    .edge_time  (s1_time_r),
    .last_time  (last_time_r),
    .shift      (shift_r),
    .cfg        (cfg),
    .dec        (dec)
  );

  // stage advances unless it has a result and the output is still full
  assign s1_advance = s1_valid_r && (!dec.emit || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_take    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_advance && dec.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_time_r <= '0;
      shift_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_advance) begin
        last_time_r <= s1_time_r;
        shift_r     <= dec.next_shift;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_edge_level;
      s1_time_r  <= in_edge_time;
    end
    if (s1_advance && dec.emit) begin
      out_word_r <= shift_r;
      out_time_r <= s1_time_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_minute_word = out_word_r;
  assign out_marker_time = out_time_r;

  // checks
  `ASSERT_NEXT(a_emit_shows, clk, rst_n, s1_advance && dec.emit, out_valid_r)
  `ASSERT_IMP(a_stall_cause, clk, rst_n, s1_valid_r && !in_ready, dec.emit && out_valid_r && !out_ready)
  `ASSERT_NEXT(a_last_time, clk, rst_n, s1_advance, last_time_r == $past(s1_time_r))

endmodule

`default_nettype wire

/* tb/sv/tb_dcf77_pulse_width_decoder.sv */
// self-checking testbench for dcf77_pulse_width_decoder: drives edge words,
// window writes and result back-pressure, and checks each minute word on the fly
// depends on dcf_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb_dcf77_pulse_width_decoder;

  localparam int TIME_W        = dcf_pkg::TIME_W;
  localparam int WORD_W        = dcf_pkg::WORD_W;
  localparam int TICK_W        = dcf_pkg::TICK_W;
  localparam int CIDX_W        = dcf_pkg::CIDX_W;
  localparam int NUM_REGS      = dcf_pkg::REG_ONE_PULSE_MAX + 1;
  localparam int TICK_MAX      = (1 << TICK_W) - 1;
  localparam int IDX_MAX       = (1 << CIDX_W) - 1;
  localparam int IDLE_PCT      = 28;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_LIMIT    = 5000;

  // one expected minute word
  typedef struct {
    logic [WORD_W-1:0] word;
    logic [TIME_W-1:0] stamp;
  } minute_t;

  // tracks window bounds, last edge time and the minute register,
  // and queues the minute words the decoder must produce
  class minute_tracker;
    logic [TICK_W-1:0] bounds [NUM_REGS];
    logic [TIME_W-1:0] prev_stamp;
    logic [WORD_W-1:0] bits;
    minute_t           minutes_due [$];
    int                minutes_made;
    int                errors;

    function new();
      bounds[dcf_pkg::REG_SECOND_GAP_MIN] = dcf_pkg::RST_SECOND_GAP_MIN;
      bounds[dcf_pkg::REG_SECOND_GAP_MAX] = dcf_pkg::RST_SECOND_GAP_MAX;
      bounds[dcf_pkg::REG_MARKER_GAP_MIN] = dcf_pkg::RST_MARKER_GAP_MIN;
      bounds[dcf_pkg::REG_MARKER_GAP_MAX] = dcf_pkg::RST_MARKER_GAP_MAX;
      bounds[dcf_pkg::REG_ZERO_PULSE_MIN] = dcf_pkg::RST_ZERO_PULSE_MIN;
      bounds[dcf_pkg::REG_ZERO_PULSE_MAX] = dcf_pkg::RST_ZERO_PULSE_MAX;
      bounds[dcf_pkg::REG_ONE_PULSE_MIN]  = dcf_pkg::RST_ONE_PULSE_MIN;
      bounds[dcf_pkg::REG_ONE_PULSE_MAX]  = dcf_pkg::RST_ONE_PULSE_MAX;
      prev_stamp   = '0;
      bits         = '0;
      minutes_made = 0;
      errors       = 0;
    endfunction

    // writes past the last register are dropped
    function void load_bound(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] val);
      if (idx < NUM_REGS) bounds[idx] = val;
    endfunction

    function bit fits(logic [TIME_W-1:0] width, dcf_pkg::cfg_reg_t lo,
                      dcf_pkg::cfg_reg_t hi);
      return width >= TIME_W'(bounds[lo]) && width <= TIME_W'(bounds[hi]);
    endfunction

    function int pending();
      return minutes_due.size();
    endfunction

    // note one accepted edge word
    function void take_edge(logic level, logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] width;
      minute_t           m;
      width      = stamp - prev_stamp;
      prev_stamp = stamp;
      if (level) begin
        // a regular second gap leaves the minute open
        if (fits(width, dcf_pkg::REG_SECOND_GAP_MIN, dcf_pkg::REG_SECOND_GAP_MAX)) return;
        if (fits(width, dcf_pkg::REG_MARKER_GAP_MIN, dcf_pkg::REG_MARKER_GAP_MAX)) begin
          m.word  = bits;
          m.stamp = stamp;
          minutes_due.push_back(m);
          minutes_made++;
        end
        bits = '0;
      end else begin
        // full register restarts, empty one gets the sentinel
        if (bits[WORD_W-1]) bits = '0;
        if (bits == '0) bits = WORD_W'(1);
        if (fits(width, dcf_pkg::REG_ZERO_PULSE_MIN, dcf_pkg::REG_ZERO_PULSE_MAX))
          bits = {bits[WORD_W-2:0], 1'b0};
        else if (fits(width, dcf_pkg::REG_ONE_PULSE_MIN, dcf_pkg::REG_ONE_PULSE_MAX))
          bits = {bits[WORD_W-2:0], 1'b1};
        else
          bits = '0;
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // compare one accepted minute word with the oldest expectation
    task check_minute(logic [WORD_W-1:0] word, logic [TIME_W-1:0] stamp);
      minute_t m;
      if (minutes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected minute word %h at time %h", word, stamp));
        return;
      end
      m = minutes_due.pop_front();
      if (word !== m.word)
        report_mismatch($sformatf("minute word %h, want %h", word, m.word));
      if (stamp !== m.stamp)
        report_mismatch($sformatf("marker time %h, want %h", stamp, m.stamp));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_edge_level;
  logic [TIME_W-1:0] in_edge_time;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_minute_word;
  logic [TIME_W-1:0] out_marker_time;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [TICK_W-1:0] cfg_data;

  minute_tracker     tracker;
  logic [TIME_W-1:0] last_stamp;
  logic [TICK_W-1:0] plan [NUM_REGS];
  int                edges_sent;
  bit                steady;
  bit                hold_request;

  dcf77_pulse_width_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_edge_level  (in_edge_level),
    .in_edge_time   (in_edge_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_minute_word(out_minute_word),
    .out_marker_time(out_marker_time),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // handshake monitor feeding the tracker
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.load_bound(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.take_edge(in_edge_level, in_edge_time);
      if (out_valid && out_ready) tracker.check_minute(out_minute_word, out_marker_time);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // offer one edge word at an absolute time and wait for it to be taken
  task automatic send_at(logic level, logic [TIME_W-1:0] stamp);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_edge_level <= level;
    in_edge_time  <= stamp;
    last_stamp     = stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edges_sent++;
  endtask

  task automatic send_after(logic level, logic [TIME_W-1:0] width);
    send_at(level, last_stamp + width);
  endtask

  // width that fits no window in particular
  function automatic logic [TIME_W-1:0] stray_width();
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return $urandom_range(TICK_MAX + 8);
      default: return $urandom_range(600);
    endcase
  endfunction

  // width inside a window, biased to its bounds; now and then a stray one
  function automatic logic [TIME_W-1:0] pick_width(dcf_pkg::cfg_reg_t lo_reg,
                                                   dcf_pkg::cfg_reg_t hi_reg);
    logic [TICK_W-1:0] lo;
    logic [TICK_W-1:0] hi;
    lo = tracker.bounds[lo_reg];
    hi = tracker.bounds[hi_reg];
    if (lo > hi || $urandom_range(49) == 0) return stray_width();
    case ($urandom_range(3))
      0:       return TIME_W'(lo);
      1:       return TIME_W'(hi);
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // well-formed minute: pulses separated by second gaps, closed by a marker gap
  task automatic send_minute(int nbits);
    for (int i = 0; i < nbits; i++) begin
      if (i > 0)
        send_after(1'b1, pick_width(dcf_pkg::REG_SECOND_GAP_MIN, dcf_pkg::REG_SECOND_GAP_MAX));
      if ($urandom_range(1))
        send_after(1'b0, pick_width(dcf_pkg::REG_ONE_PULSE_MIN, dcf_pkg::REG_ONE_PULSE_MAX));
      else
        send_after(1'b0, pick_width(dcf_pkg::REG_ZERO_PULSE_MIN, dcf_pkg::REG_ZERO_PULSE_MAX));
    end
    send_after(1'b1, pick_width(dcf_pkg::REG_MARKER_GAP_MIN, dcf_pkg::REG_MARKER_GAP_MAX));
  endtask

  // mostly minutes, some short and some long enough to fill the register
  task automatic run_random(int quota, int want_minutes);
    int start;
    start = edges_sent;
    while (edges_sent - start < quota || tracker.minutes_made < want_minutes) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(9) < 7) send_minute($urandom_range(16));
        else send_minute($urandom_range(70, 50));
      end else begin
        repeat ($urandom_range(6, 1)) send_after(1'($urandom_range(1)), stray_width());
      end
    end
  endtask

  // drop valid and wait until the block has nothing left in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all eight bounds, then a write to an unused index that must be dropped
  task automatic apply_plan();
    for (int k = 0; k < NUM_REGS; k++) write_reg(CIDX_W'(k), plan[k]);
    write_reg(CIDX_W'($urandom_range(IDX_MAX, NUM_REGS)), TICK_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_windows(int sec_lo, int sec_hi, int mk_lo, int mk_hi,
                              int z_lo, int z_hi, int o_lo, int o_hi);
    plan[dcf_pkg::REG_SECOND_GAP_MIN] = TICK_W'(sec_lo);
    plan[dcf_pkg::REG_SECOND_GAP_MAX] = TICK_W'(sec_hi);
    plan[dcf_pkg::REG_MARKER_GAP_MIN] = TICK_W'(mk_lo);
    plan[dcf_pkg::REG_MARKER_GAP_MAX] = TICK_W'(mk_hi);
    plan[dcf_pkg::REG_ZERO_PULSE_MIN] = TICK_W'(z_lo);
    plan[dcf_pkg::REG_ZERO_PULSE_MAX] = TICK_W'(z_hi);
    plan[dcf_pkg::REG_ONE_PULSE_MIN]  = TICK_W'(o_lo);
    plan[dcf_pkg::REG_ONE_PULSE_MAX]  = TICK_W'(o_hi);
  endtask

  // random windows; wild pairs may come out empty or span everything
  task automatic plan_random(bit wild);
    int lo;
    for (int p = 0; p < NUM_REGS; p += 2) begin
      if (wild && $urandom_range(1)) begin
        plan[p]     = TICK_W'($urandom_range(TICK_MAX));
        plan[p + 1] = TICK_W'($urandom_range(TICK_MAX));
      end else begin
        lo          = $urandom_range(600);
        plan[p]     = TICK_W'(lo);
        plan[p + 1] = TICK_W'(lo + $urandom_range(300));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_edge_level = 1'b0;
    in_edge_time  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    steady        = 1'b0;
    hold_request  = 1'b0;
    last_stamp    = '0;
    edges_sent    = 0;
    tracker       = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed edges on the reset windows; first width counts from time zero
    send_after(1'b0, 20);
    send_after(1'b1, 200);
    send_after(1'b0, 50);
    send_after(1'b1, TIME_W'(dcf_pkg::RST_SECOND_GAP_MIN));
    send_after(1'b0, TIME_W'(dcf_pkg::RST_ZERO_PULSE_MIN));
    send_after(1'b1, TIME_W'(dcf_pkg::RST_SECOND_GAP_MAX));
    send_after(1'b0, TIME_W'(dcf_pkg::RST_ZERO_PULSE_MAX));
    send_after(1'b1, TIME_W'(dcf_pkg::RST_SECOND_GAP_MIN));
    send_after(1'b0, TIME_W'(dcf_pkg::RST_ONE_PULSE_MIN));
    send_after(1'b1, TIME_W'(dcf_pkg::RST_SECOND_GAP_MAX));
    send_after(1'b0, TIME_W'(dcf_pkg::RST_ONE_PULSE_MAX));
    send_after(1'b1, TIME_W'(dcf_pkg::RST_MARKER_GAP_MIN));
    // pulse between the zero and one windows clears, marker then gives zero
    send_after(1'b0, 34);
    send_after(1'b1, TIME_W'(dcf_pkg::RST_MARKER_GAP_MAX));
    send_after(1'b1, 300);
    send_after(1'b0, 60);
    send_after(1'b1, 178);
    send_after(1'b1, 513);
    // timestamp wrap
    send_at(1'b0, 32'hFFFF_FFF0);
    send_after(1'b0, 32);
    send_after(1'b1, 200);
    send_after(1'b0, 9);
    send_after(1'b0, 45);
    send_after(1'b1, 500);
    send_after(1'b1, 0);

    run_random(350, 0);
    settle();

    // random realistic windows, no idling on either side
    plan_random(1'b0);
    apply_plan();
    steady = 1'b1;
    run_random(300, 0);
    steady = 1'b0;
    settle();

    // every rising gap up to TICK_MAX is a marker and the zero window shadows the one window;
    // results back up and stall the input while the receiver holds off
    plan_windows(TICK_MAX, 0, 0, TICK_MAX, 0, TICK_MAX, 0, TICK_MAX);
    apply_plan();
    hold_request = 1'b1;
    run_random(300, 0);
    settle();

    // single-value windows at both ends of the range
    plan_windows(0, 0, TICK_MAX, TICK_MAX, 0, 0, TICK_MAX, TICK_MAX);
    apply_plan();
    run_random(200, 0);
    settle();

    plan_random(1'b1);
    apply_plan();
    run_random(350, 0);
    settle();

    // back to the nominal windows
    plan_windows(dcf_pkg::RST_SECOND_GAP_MIN, dcf_pkg::RST_SECOND_GAP_MAX,
                 dcf_pkg::RST_MARKER_GAP_MIN, dcf_pkg::RST_MARKER_GAP_MAX,
                 dcf_pkg::RST_ZERO_PULSE_MIN, dcf_pkg::RST_ZERO_PULSE_MAX,
                 dcf_pkg::RST_ONE_PULSE_MIN, dcf_pkg::RST_ONE_PULSE_MAX);
    apply_plan();
    run_random(450, 40);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
